### sv/smvlq_pkg.sv
// Shared types, character codes and the base64 digit decoder.
package smvlq_pkg;

  localparam int MAX_FIELDS = 5;
  localparam int LINE_W     = 24;
  localparam int FIELD_W    = 32;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  // One classified input character.
  typedef struct packed {
    logic [5:0] digit;  // base64 value, bit 5 is the continuation flag
    logic       sep;    // comma or semicolon
    logic       semi;   // semicolon
    logic       last;   // final character of the string
  } token_t;

  // One decoded segment.
  typedef struct packed {
    logic [LINE_W-1:0]                   gen_line;
    logic [MAX_FIELDS-1:0][FIELD_W-1:0]  field_val;
    logic [MAX_FIELDS-1:0]               present_mask;
    logic                                line_end;
  } result_t;

  // Base64 alphabet; anything else decodes as zero.
  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [5:0] d;
    d = 6'd0;
    case (c) inside
      [8'h41:8'h5A]: d = 6'(c - 8'h41);
      [8'h61:8'h7A]: d = 6'(c - 8'h61 + 8'd26);
      [8'h30:8'h39]: d = 6'(c - 8'h30 + 8'd52);
      8'h2B:         d = 6'd62;
      8'h2F:         d = 6'd63;
      default:       d = 6'd0;
    endcase
    return d;
  endfunction

endpackage

### sv/smvlq_fifo.sv
// Small flip-flop queue with push/full and pop/empty sides.
module smvlq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/smvlq_front.sv
// Front end: classifies each character and queues it for the decoder.
module smvlq_front import smvlq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_char,
  input  logic       end_of_text,
  input  logic       tok_pop,
  output logic       tok_empty,
  output token_t     tok
);

  token_t                tok_in;
  logic                  q_full;
  logic [$bits(token_t)-1:0] q_rdata;

  always_comb begin
    tok_in.semi  = (text_char == CH_SEMI);
    tok_in.sep   = tok_in.semi || (text_char == CH_COMMA);
    tok_in.digit = digit_value(text_char);
    tok_in.last  = end_of_text;
  end

  // hold off the source while in reset
  assign full = q_full || rst;
  assign tok  = token_t'(q_rdata);

  smvlq_fifo #(
    .WIDTH ($bits(token_t)),
    .DEPTH (2)
  ) u_tok_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !rst),
    .wdata (tok_in),
    .full  (q_full),
    .pop   (tok_pop),
    .rdata (q_rdata),
    .empty (tok_empty)
  );

endmodule

### sv/smvlq_back.sv
// Back end: VLQ digit assembly, zigzag unfold, running fields, segment close.
module smvlq_back import smvlq_pkg::*; #(
  parameter int NUM_FIELDS = 5
) (
  input  logic    clk,
  input  logic    rst,
  input  token_t  tok,
  input  logic    tok_empty,
  output logic    tok_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  logic [FIELD_W-1:0] accum;
  logic [5:0]         shift;
  logic [2:0]         fp;
  logic [FIELD_W-1:0] run [MAX_FIELDS];
  logic [MAX_FIELDS-1:0] mask;
  logic               line_start;
  logic [LINE_W-1:0]  line_count;

  logic [FIELD_W-1:0] accum_add;
  logic [6:0]         shift_sum;
  logic [5:0]         shift_add;
  logic               fin;
  logic               close;
  logic               emit;
  logic [FIELD_W-1:0] num;
  logic [FIELD_W-1:0] mag;
  logic [2:0]         fp_fin;
  logic [MAX_FIELDS-1:0] mask_fin;
  logic [FIELD_W-1:0] run_fin [MAX_FIELDS];

  assign tok_pop  = !tok_empty && !res_full;
  assign close    = tok.sep || tok.last;

  always_comb begin
    // accum only holds bits below shift, so OR places the new group
    accum_add = accum;
    if (!shift[5]) begin
      accum_add = accum | (FIELD_W'(tok.digit[4:0]) << shift[4:0]);
    end
    shift_sum = {1'b0, shift} + 7'd5;
    shift_add = (shift_sum > 7'd63) ? 6'd63 : shift_sum[5:0];
    fin = tok.sep ? (shift != 6'd0) : (!tok.digit[5] || tok.last);
    num = tok.sep ? accum : accum_add;
    mag = num >> 1;
    fp_fin = fin ? ((fp == 3'd7) ? 3'd7 : fp + 3'd1) : fp;
    emit = close && (fp_fin != 3'd0);
  end

  for (genvar k = 0; k < MAX_FIELDS; k++) begin : g_field
    if (k < NUM_FIELDS) begin : g_live
      logic [FIELD_W-1:0] base;
      logic               hit;
      assign hit  = fin && (fp == 3'(k));
      assign base = ((k == 0) && line_start) ? '0 : run[k];
      assign run_fin[k]  = hit ? (num[0] ? base - mag : base + mag) : run[k];
      assign mask_fin[k] = mask[k] | hit;

      always_ff @(posedge clk) begin
        if (rst) begin
          run[k] <= '0;
        end else if (tok_pop) begin
          run[k] <= tok.last ? '0 : run_fin[k];
        end
      end
    end else begin : g_dead
      assign run[k]      = '0;
      assign run_fin[k]  = '0;
      assign mask_fin[k] = 1'b0;
    end
  end

  always_comb begin
    res.gen_line     = line_count;
    res.present_mask = mask_fin;
    res.line_end     = tok.semi || tok.last;
    for (int k = 0; k < MAX_FIELDS; k++) begin
      res.field_val[k] = run_fin[k];
    end
  end

  assign res_push = tok_pop && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      accum      <= '0;
      shift      <= '0;
      fp         <= '0;
      mask       <= '0;
      line_start <= 1'b1;
      line_count <= '0;
    end else if (tok_pop) begin
      if (tok.last) begin
        accum      <= '0;
        shift      <= '0;
        fp         <= '0;
        mask       <= '0;
        line_start <= 1'b1;
        line_count <= '0;
      end else if (close) begin
        accum <= '0;
        shift <= '0;
        fp    <= '0;
        mask  <= mask_fin;
        if (tok.semi) begin
          line_start <= 1'b1;
          if (line_count != '1) begin
            line_count <= line_count + 1'b1;
          end
        end else if (emit) begin
          line_start <= 1'b0;
        end
      end else begin
        accum <= fin ? '0 : accum_add;
        shift <= fin ? '0 : shift_add;
        fp    <= fp_fin;
        mask  <= mask_fin;
      end
    end
  end

  a_emit_on_consume: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (tok_pop && close))
    else $error("segment emitted without a closing character");

  a_clean_upper: assert property (@(posedge clk) disable iff (rst)
    !shift[5] |-> ((accum >> shift[4:0]) == '0))
    else $error("accumulator has bits above the digit position");

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (tok_pop && tok.last) |=> (fp == 3'd0 && line_count == '0 && line_start && mask == '0))
    else $error("state not cleared after end of text");

endmodule

### sv/source_map_vlq_mapping_decoder.sv
// Top level: source map v3 base64 VLQ mappings decoder.
//
//  channel   | handshake          | words
//  ----------+--------------------+---------------------------------------------
//  input     | push / full        | text_char, end_of_text (one character)
//  result    | pop / empty        | gen_line, gen_column, src_index,
//            |                    | orig_line, orig_column, name_index,
//            |                    | present_mask, line_end (one segment)
//
// One character is taken per clock while full is low. The front classifies it and
// queues a token; the back runs one token per clock while the result queue has
// room, through a single add/subtract per field, so the sustained rate is one
// character per cycle when results are taken. A segment result passes through the
// token queue, then the decoder into the result queue, before it appears on the
// result ports.
// rst is synchronous: both queues empty, decoder back to its start state;
// full is held high while rst is high.
// A stalled result side fills the two-word result queue, then the two-word
// token queue, and only then raises full.
module source_map_vlq_mapping_decoder import smvlq_pkg::*; #(
  parameter int NUM_FIELDS = 5
) (
  input  logic               clk,
  input  logic               rst,
  // character input
  input  logic               push,
  output logic               full,
  input  logic [7:0]         text_char,
  input  logic               end_of_text,
  // segment output
  input  logic               pop,
  output logic               empty,
  output logic [23:0]        gen_line,
  output logic signed [31:0] gen_column,
  output logic signed [31:0] src_index,
  output logic signed [31:0] orig_line,
  output logic signed [31:0] orig_column,
  output logic signed [31:0] name_index,
  output logic [4:0]         present_mask,
  output logic               line_end
);

  token_t  tok;
  logic    tok_empty;
  logic    tok_pop;
  logic    res_full;
  logic    res_push;
  result_t res_in;
  result_t res_out;
  logic [$bits(result_t)-1:0] res_rdata;

  // front: character classification and token queue
  smvlq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .text_char   (text_char),
    .end_of_text (end_of_text),
    .tok_pop     (tok_pop),
    .tok_empty   (tok_empty),
    .tok         (tok)
  );

  // back: number assembly and running fields
  smvlq_back #(
    .NUM_FIELDS (NUM_FIELDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok),
    .tok_empty (tok_empty),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // result queue decouples the consumer from the decoder
  smvlq_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out      = result_t'(res_rdata);
  assign gen_line     = res_out.gen_line;
  assign gen_column   = res_out.field_val[0];
  assign src_index    = res_out.field_val[1];
  assign orig_line    = res_out.field_val[2];
  assign orig_column  = res_out.field_val[3];
  assign name_index   = res_out.field_val[4];
  assign present_mask = res_out.present_mask;
  assign line_end     = res_out.line_end;

endmodule

### sim/vlq_segment_checker.sv
// Predicts decoded mapping segments from accepted characters and checks the result words.
module vlq_segment_checker import smvlq_pkg::*; #(
  parameter int NUM_FIELDS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  text_char,
  input  logic        end_of_text,
  input  logic        pop,
  input  logic        empty,
  input  logic [23:0] gen_line,
  input  logic [31:0] gen_column,
  input  logic [31:0] src_index,
  input  logic [31:0] orig_line,
  input  logic [31:0] orig_column,
  input  logic [31:0] name_index,
  input  logic [4:0]  present_mask,
  input  logic        line_end,
  output int          errors,
  output int          pending,
  output int          chars_seen,
  output int          segs_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LINE_W-1:0]                  ln;
    logic [MAX_FIELDS-1:0][FIELD_W-1:0] val;
    logic [MAX_FIELDS-1:0]              mask;
    logic                               closes_line;
  } segment_t;

  segment_t segments_due[$];

  // decoder state
  logic [31:0]        acc;
  logic [5:0]         shift;
  logic [2:0]         fpos;
  logic [31:0]        run_val [MAX_FIELDS];
  logic [4:0]         seen_mask;
  logic               at_line_start;
  logic [LINE_W-1:0]  line_no;

  function automatic logic [5:0] b64_code(logic [7:0] c);
    if (c >= "A" && c <= "Z") return 6'(c - "A");
    if (c >= "a" && c <= "z") return 6'(c - "a" + 26);
    if (c >= "0" && c <= "9") return 6'(c - "0" + 52);
    if (c == "+") return 6'd62;
    if (c == "/") return 6'd63;
    return 6'd0;
  endfunction

  function automatic void clear_state();
    acc = '0;
    shift = '0;
    fpos = '0;
    for (int k = 0; k < MAX_FIELDS; k++) run_val[k] = '0;
    seen_mask = '0;
    at_line_start = 1'b1;
    line_no = '0;
  endfunction

  // zigzag unfold, then absolute or relative update of the field
  function automatic void close_number();
    logic [31:0] mag;
    logic [31:0] v;
    mag = acc >> 1;
    v = acc[0] ? 32'd0 - mag : mag;
    if (fpos < NUM_FIELDS) begin
      if (fpos == 0 && at_line_start) run_val[0] = v;
      else run_val[fpos] = run_val[fpos] + v;
      seen_mask[fpos] = 1'b1;
    end
    if (fpos < 3'd7) fpos = fpos + 3'd1;
    acc = '0;
    shift = '0;
  endfunction

  function automatic void take_digit(logic [5:0] d);
    logic [31:0] grp;
    grp = {27'd0, d[4:0]};
    if (shift < 6'd32) acc = acc + (grp << shift);
    shift = (int'(shift) + 5 > 63) ? 6'd63 : shift + 6'd5;
    if (!d[5]) close_number();
  endfunction

  function automatic void decode_char(logic [7:0] c, logic last);
    logic     semi;
    logic     sep;
    segment_t s;
    semi = (c == CH_SEMI);
    sep  = semi || (c == CH_COMMA);
    if (!sep) take_digit(b64_code(c));
    if (sep || last) begin
      if (shift != 0) close_number();
      if (fpos != 0) begin
        s.ln = line_no;
        for (int k = 0; k < MAX_FIELDS; k++) s.val[k] = run_val[k];
        s.mask = seen_mask;
        s.closes_line = semi || last;
        segments_due = {segments_due, s};
        at_line_start = 1'b0;
      end
      fpos = '0;
      acc = '0;
      shift = '0;
      if (semi) begin
        at_line_start = 1'b1;
        if (line_no != '1) line_no = line_no + 1'b1;
      end
    end
    if (last) clear_state();
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("MISMATCH %s: expected %08h, got %08h (segment %0d)", what, want, got, segs_seen);
    errors++;
  endtask

  task automatic check_segment();
    segment_t s;
    if (segments_due.size() == 0) begin
      flag_mismatch("segment word with none due", 32'd0, gen_column);
    end else begin
      s = segments_due.pop_front();
      if (gen_line !== s.ln)            flag_mismatch("gen_line", 32'(s.ln), 32'(gen_line));
      if (gen_column !== s.val[0])      flag_mismatch("gen_column", s.val[0], gen_column);
      if (src_index !== s.val[1])       flag_mismatch("src_index", s.val[1], src_index);
      if (orig_line !== s.val[2])       flag_mismatch("orig_line", s.val[2], orig_line);
      if (orig_column !== s.val[3])     flag_mismatch("orig_column", s.val[3], orig_column);
      if (name_index !== s.val[4])      flag_mismatch("name_index", s.val[4], name_index);
      if (present_mask !== s.mask)      flag_mismatch("present_mask", 32'(s.mask),
                                                      32'(present_mask));
      if (line_end !== s.closes_line)   flag_mismatch("line_end", 32'(s.closes_line),
                                                      32'(line_end));
    end
    segs_seen++;
  endtask

  initial clear_state();

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      segments_due.delete();
    end else begin
      if (pop && !empty) check_segment();
      if (push && !full) begin
        decode_char(text_char, end_of_text);
        chars_seen++;
      end
    end
    pending = segments_due.size();
  end

endmodule

### sim/testbench.sv
// Top-level testbench: drives mappings text into the VLQ decoder and gives the verdict.
module testbench;
  import smvlq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    NUM_FIELDS   = 5;
  localparam int    PHASE_CHARS  = 500;     // random characters per pacing phase
  localparam int    CYCLE_LIMIT  = 200000;  // watchdog bound on simulated cycles
  localparam int    SETTLE_CYCLES = 16;     // settling time before the verdict for stray result words
  localparam string B64 = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int    CONT_FLAG = 32;         // continuation bit of a base64 digit

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  text_char = 8'h00;
  logic        end_of_text = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [23:0] gen_line;
  logic signed [31:0] gen_column, src_index, orig_line, orig_column, name_index;
  logic [4:0]  present_mask;
  logic        line_end;

  int errors, pending, chars_seen, segs_seen;
  int idle_pct  = 0;   // chance the sender holds off before a word
  int stall_pct = 0;   // chance the receiver refuses a word
  int cycle_cnt = 0;
  int sent_chars;

  // characters of the segment being built
  logic [7:0] text_q[$];

  source_map_vlq_mapping_decoder #(.NUM_FIELDS(NUM_FIELDS)) u_top (
    .clk, .rst, .push, .full, .text_char, .end_of_text,
    .pop, .empty, .gen_line, .gen_column, .src_index, .orig_line,
    .orig_column, .name_index, .present_mask, .line_end
  );

  vlq_segment_checker #(.NUM_FIELDS(NUM_FIELDS)) u_checker (
    .clk, .rst, .push, .full, .text_char, .end_of_text,
    .pop, .empty, .gen_line,
    .gen_column(gen_column), .src_index(src_index), .orig_line(orig_line),
    .orig_column(orig_column), .name_index(name_index),
    .present_mask, .line_end,
    .errors, .pending, .chars_seen, .segs_seen
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: pop decided once per cycle at the falling edge.
  always @(negedge clk) pop <= ($urandom_range(99) >= stall_pct);

  // Watchdog: hard stop if the run hangs.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Offer one character word; called right after a falling edge, returns after one.
  // The word is taken at the first rising edge that sees full low.
  task automatic send_char(logic [7:0] c, logic last);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    text_char <= c;
    end_of_text <= last;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    @(negedge clk);
    sent_chars++;
  endtask

  task automatic send_text(string s, logic last_on_final);
    for (int i = 0; i < s.len(); i++) send_char(s[i], last_on_final && i == s.len() - 1);
  endtask

  // Hold the input side quiet until every predicted segment has come out.
  task automatic drain_results();
    push <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  // Base64 VLQ of a signed value, least significant group first.
  function automatic void append_vlq(longint v);
    logic [63:0] zig;
    int d;
    zig = (v < 0) ? (((-v) << 1) | 64'd1) : (v << 1);
    do begin
      d = int'(zig[4:0]);
      zig = zig >> 5;
      if (zig != 0) d = d + CONT_FLAG;
      text_q = {text_q, B64[d]};
    end while (zig != 0);
  endfunction

  // Mostly small deltas like real maps, sometimes wide and extreme values.
  function automatic longint pick_delta();
    int r;
    r = $urandom_range(99);
    if (r < 50) return longint'($urandom_range(80)) - 40;
    if (r < 80) return longint'($urandom_range(10000)) - 5000;
    if (r < 95) return longint'($signed($urandom()));
    case ($urandom_range(3))
      0: return -64'sd2147483648;
      1: return 64'sd2147483647;
      2: return 64'sd0;
      default: return -64'sd1;
    endcase
  endfunction

  // One number slot: usually well formed, sometimes truncated, overlong or garbage.
  function automatic void append_field();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 88) begin
      append_vlq(pick_delta());
    end else if (r < 93) begin
      // continuation left pending; the next separator or digit resolves it
      n = $urandom_range(1, 3);
      repeat (n) text_q = {text_q, B64[CONT_FLAG + $urandom_range(31)]};
    end else if (r < 97) begin
      // groups past bit 32 must add nothing
      n = $urandom_range(7, 10);
      repeat (n) text_q = {text_q, B64[CONT_FLAG + $urandom_range(31)]};
      text_q = {text_q, B64[$urandom_range(31)]};
    end else begin
      text_q = {text_q, 8'($urandom_range(128, 255))};
    end
  endfunction

  // Build and send one segment with its separator; occasionally ends the text.
  task automatic send_random_segment();
    int r;
    int nf;
    logic last;
    text_q.delete();
    last = 1'b0;
    r = $urandom_range(99);
    if (r < 6) begin
      // raw noise, separators included
      repeat ($urandom_range(1, 6)) text_q = {text_q, 8'($urandom_range(255))};
    end else begin
      r = $urandom_range(99);
      nf = (r < 10) ? 0 : (r < 35) ? 1 : (r < 60) ? 4 : (r < 90) ? 5 : $urandom_range(6, 7);
      repeat (nf) append_field();
      r = $urandom_range(99);
      if (r < 3 && text_q.size() != 0) begin
        last = 1'b1;  // text ends on a digit, no separator
      end else begin
        text_q = {text_q, (($urandom_range(99) < 30) ? CH_SEMI : CH_COMMA)};
        last = (r < 6);
      end
    end
    foreach (text_q[i]) send_char(text_q[i], last && i == text_q.size() - 1);
  endtask

  initial begin
    sent_chars = 0;
    // hold synchronous reset, then release it
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: multi-digit number and fields past the fifth, comma close
    send_text("gBCDEFGH,", 1'b0);
    // empty segment still advances the line
    send_text(";", 1'b0);
    // overlong number cut by a semicolon while a continuation is pending
    send_text("////////;", 1'b0);
    // invalid bytes at both ends of the range decode as zero digits
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_COMMA, 1'b0);
    // end of text on a digit closes the segment and restarts the decoder
    send_char("B", 1'b1);
    drain_results();

    // Random text under four pacing mixes; drain between them.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      sent_chars = 0;
      while (sent_chars < PHASE_CHARS) send_random_segment();
      drain_results();
    end

    // let any stray segment word show up before the verdict
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d characters and %0d decoded segments", chars_seen, segs_seen);
    $display("over four pacing mixes of sender gaps and receiver stalls.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
